[rtl/core/dll_pkg.sv]
// dll_pkg: types and codes shared by the doubly linked list engine.
// No dependencies.
package dll_pkg;

    localparam int MODE_W   = 4;
    localparam int HANDLE_W = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_POS   = 4'd2,
        OP_RM_FRONT  = 4'd3,
        OP_RM_BACK   = 4'd4,
        OP_RM_POS    = 4'd5,
        OP_RM_VALUE  = 4'd6,
        OP_READ_POS  = 4'd7,
        OP_READ_FRNT = 4'd8,
        OP_READ_BACK = 4'd9,
        OP_SEARCH    = 4'd10,
        OP_TRAVERSE  = 4'd11,
        OP_CLEAR     = 4'd12
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [HANDLE_W-1:0] handle;
        logic [POS_W-1:0]    position;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] result_handle;
        logic [COUNT_W-1:0]  element_count;
        logic                is_empty;
        logic                last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_WALK_WAIT,
        S_LINK_A,
        S_LINK_B,
        S_UNLINK,
        S_UNLINK_B,
        S_TRAV,
        S_DONE
    } t_state;

endpackage

[rtl/core/dll_node_mem.sv]
// dll_node_mem: node store (handle, next, prev), one write and one read port,
// registered read data. Depends on nothing.
module dll_node_mem #(
    parameter int CAPACITY = 64,
    parameter int HB       = 32,
    parameter int IW       = 7
) (
    input  logic            i_clk,
    input  logic            i_we_h,
    input  logic            i_we_n,
    input  logic            i_we_p,
    input  logic [IW-1:0]   i_waddr,
    input  logic [HB-1:0]   i_wh,
    input  logic [IW-1:0]   i_wn,
    input  logic [IW-1:0]   i_wp,
    input  logic [IW-1:0]   i_raddr,
    output logic [HB-1:0]   o_rh,
    output logic [IW-1:0]   o_rn,
    output logic [IW-1:0]   o_rp
);
    localparam int AW = $clog2(CAPACITY);

    logic [HB-1:0] mem_h [CAPACITY];
    logic [IW-1:0] mem_n [CAPACITY];
    logic [IW-1:0] mem_p [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we_h) mem_h[i_waddr[AW-1:0]] <= i_wh;
        if (i_we_n) mem_n[i_waddr[AW-1:0]] <= i_wn;
        if (i_we_p) mem_p[i_waddr[AW-1:0]] <= i_wp;
        o_rh <= mem_h[i_raddr[AW-1:0]];
        o_rn <= mem_n[i_raddr[AW-1:0]];
        o_rp <= mem_p[i_raddr[AW-1:0]];
    end
endmodule

[rtl/core/doubly_linked_list_engine.sv]
// Doubly linked list engine top level: sequencer around the node store.
// Depends on dll_pkg and dll_node_mem.
//
// One request at a time; busy is high from acceptance until the final result.
// Front/back inserts and removes and front/back reads do not walk the list.
// Positional operations, search and remove by value walk the list one node
// at a time (one node store read each, with registered read data). Traverse
// emits one result per node walked. Results come as one-cycle strobes on
// o_valid and must be taken.
module doubly_linked_list_engine #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  dll_pkg::t_req   i_req,
    output logic            o_valid,
    output dll_pkg::t_rsp   o_rsp
);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int HB = dll_pkg::HANDLE_W;
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);
    localparam logic [HB-1:0] HMASK = (HANDLE_BITS >= HB) ? {HB{1'b1}}
                                      : HB'((64'd1 << HANDLE_BITS) - 64'd1);

    dll_pkg::t_state r_state, n_state;
    logic [IW-1:0] r_head, n_head, r_tail, n_tail, r_cnt, n_cnt;
    logic [IW-1:0] r_free, n_free, r_nun, n_nun;
    logic [dll_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [HB-1:0] r_h, n_h, r_rh, n_rh;
    logic [dll_pkg::POS_W-1:0] r_pos, n_pos;
    logic [IW-1:0] r_cur, n_cur, r_node, n_node, r_p, n_p, r_x, n_x;
    logic [IW:0]   r_k, n_k;
    logic          r_alloc_free, n_alloc_free;
    logic          r_ov, n_ov;
    dll_pkg::t_rsp r_rsp, n_rsp;

    logic          we_h, we_n, we_p;
    logic [IW-1:0] waddr, wn, wp, raddr;
    logic [HB-1:0] rh;
    logic [IW-1:0] rn, rp;

    dll_node_mem #(.CAPACITY(CAPACITY), .HB(HB), .IW(IW)) u_mem (
        .i_clk(i_clk), .i_we_h(we_h), .i_we_n(we_n), .i_we_p(we_p),
        .i_waddr(waddr), .i_wh(r_h), .i_wn(wn), .i_wp(wp),
        .i_raddr(raddr), .o_rh(rh), .o_rn(rn), .o_rp(rp)
    );

    assign busy    = (r_state != dll_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dll_pkg::S_IDLE;
            r_head  <= NIL;
            r_tail  <= NIL;
            r_cnt   <= '0;
            r_free  <= NIL;
            r_nun   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_free  <= n_free;
            r_nun   <= n_nun;
            r_ov    <= n_ov;
        end
        r_mode <= n_mode; r_h <= n_h; r_pos <= n_pos; r_rh <= n_rh;
        r_cur <= n_cur; r_node <= n_node; r_p <= n_p; r_x <= n_x;
        r_k <= n_k; r_alloc_free <= n_alloc_free; r_rsp <= n_rsp;
    end

    function automatic dll_pkg::t_rsp mk(input logic [1:0] st, input logic [HB-1:0] h,
                                         input logic [IW-1:0] c, input logic lst);
        dll_pkg::t_rsp r;
        r.status        = st;
        r.result_handle = (st == dll_pkg::ST_OK) ? h : '0;
        r.element_count = dll_pkg::COUNT_W'(c);
        r.is_empty      = (c == '0);
        r.last          = lst;
        return r;
    endfunction

    // insert: node r_node placed between r_p and r_x
    // remove: r_node unlinked, r_p / r_x its neighbours
    always_comb begin
        logic is_ins, is_rm;
        n_state = r_state; n_head = r_head; n_tail = r_tail; n_cnt = r_cnt;
        n_free = r_free; n_nun = r_nun; n_mode = r_mode; n_h = r_h; n_pos = r_pos;
        n_rh = r_rh; n_cur = r_cur; n_node = r_node; n_p = r_p; n_x = r_x; n_k = r_k;
        n_alloc_free = r_alloc_free; n_ov = 1'b0; n_rsp = r_rsp;
        we_h = 1'b0; we_n = 1'b0; we_p = 1'b0; waddr = r_node; wn = r_x; wp = r_p;
        raddr = r_cur;
        is_ins = (r_mode == dll_pkg::OP_INS_FRONT) || (r_mode == dll_pkg::OP_INS_BACK)
              || (r_mode == dll_pkg::OP_INS_POS);
        is_rm  = (r_mode == dll_pkg::OP_RM_FRONT) || (r_mode == dll_pkg::OP_RM_BACK)
              || (r_mode == dll_pkg::OP_RM_POS) || (r_mode == dll_pkg::OP_RM_VALUE);
        case (r_state)
            dll_pkg::S_IDLE: begin
                if (start) begin
                    n_mode = i_req.mode;
                    n_h    = i_req.handle & HMASK;
                    n_pos  = i_req.position;
                    n_k    = '0;
                    n_cur  = r_head;
                    n_state = dll_pkg::S_WALK;
                    case (i_req.mode)
                        dll_pkg::OP_INS_FRONT, dll_pkg::OP_INS_BACK, dll_pkg::OP_INS_POS: begin
                            if (r_free == NIL && r_nun == NIL) begin
                                n_rsp = mk(dll_pkg::ST_FULL, '0, r_cnt, 1'b1);
                                n_state = dll_pkg::S_DONE;
                            end else begin
                                n_alloc_free = (r_free != NIL);
                                n_node = (r_free != NIL) ? r_free : r_nun;
                                if (i_req.mode == dll_pkg::OP_INS_FRONT) begin
                                    n_x = r_head; n_p = NIL; n_state = dll_pkg::S_LINK_A;
                                end else if (i_req.mode == dll_pkg::OP_INS_BACK ||
                                             {1'b0, i_req.position} >= 9'(r_cnt)) begin
                                    n_x = NIL; n_p = r_tail; n_state = dll_pkg::S_LINK_A;
                                end
                                n_cur = (r_free != NIL) ? r_free : r_head;
                                if (r_free != NIL) begin
                                    n_state = dll_pkg::S_WALK;
                                    n_k = {1'b1, {IW{1'b0}}};
                                    if (!(i_req.mode == dll_pkg::OP_INS_POS &&
                                          {1'b0, i_req.position} < 9'(r_cnt)))
                                        n_k[0] = 1'b1;
                                end
                            end
                        end
                        dll_pkg::OP_RM_FRONT, dll_pkg::OP_READ_FRNT: begin
                            n_cur = r_head;
                            if (r_head == NIL) begin
                                n_rsp = mk(dll_pkg::ST_MISS, '0, r_cnt, 1'b1);
                                n_state = dll_pkg::S_DONE;
                            end else n_pos = '0;
                        end
                        dll_pkg::OP_RM_BACK, dll_pkg::OP_READ_BACK: begin
                            n_cur = r_tail;
                            n_pos = '0;
                            if (r_tail == NIL) begin
                                n_rsp = mk(dll_pkg::ST_MISS, '0, r_cnt, 1'b1);
                                n_state = dll_pkg::S_DONE;
                            end
                        end
                        dll_pkg::OP_RM_POS, dll_pkg::OP_READ_POS: begin
                            if ({1'b0, i_req.position} >= 9'(r_cnt)) begin
                                n_rsp = mk(dll_pkg::ST_MISS, '0, r_cnt, 1'b1);
                                n_state = dll_pkg::S_DONE;
                            end
                        end
                        dll_pkg::OP_RM_VALUE, dll_pkg::OP_SEARCH, dll_pkg::OP_TRAVERSE: begin
                            if (r_head == NIL) begin
                                n_rsp = mk(dll_pkg::ST_MISS, '0, r_cnt, 1'b1);
                                n_state = dll_pkg::S_DONE;
                            end
                        end
                        dll_pkg::OP_CLEAR: begin
                            n_head = NIL; n_tail = NIL; n_cnt = '0; n_free = NIL; n_nun = '0;
                            n_rsp = mk(dll_pkg::ST_OK, '0, '0, 1'b1);
                            n_state = dll_pkg::S_DONE;
                        end
                        default: begin
                            n_rsp = mk(dll_pkg::ST_MISS, '0, r_cnt, 1'b1);
                            n_state = dll_pkg::S_DONE;
                        end
                    endcase
                end
            end
            // issue read of r_cur
            dll_pkg::S_WALK: begin
                raddr = r_cur;
                n_state = dll_pkg::S_WALK_WAIT;
            end
            dll_pkg::S_WALK_WAIT: begin
                if (r_k[IW]) begin
                    // free-list pop: rn is the next free node
                    n_free = rn;
                    n_k = '0;
                    n_cur = r_head;
                    if (r_k[0]) n_state = dll_pkg::S_LINK_A;
                    else n_state = dll_pkg::S_WALK;
                end else if (r_mode == dll_pkg::OP_TRAVERSE) begin
                    n_rsp = mk(dll_pkg::ST_OK, rh, r_cnt,
                               (rn == NIL) || (r_k + 1'b1 >= (IW+1)'(CAPACITY)));
                    n_ov = 1'b1;
                    n_k = r_k + 1'b1;
                    n_cur = rn;
                    n_state = n_rsp.last ? dll_pkg::S_IDLE : dll_pkg::S_WALK;
                end else if (r_mode == dll_pkg::OP_RM_VALUE || r_mode == dll_pkg::OP_SEARCH) begin
                    if (rh == r_h) begin
                        n_node = r_cur; n_p = rp; n_x = rn; n_rh = rh;
                        n_state = (r_mode == dll_pkg::OP_SEARCH) ? dll_pkg::S_DONE
                                                                 : dll_pkg::S_UNLINK;
                        n_rsp = mk(dll_pkg::ST_OK, rh, r_cnt, 1'b1);
                    end else if (rn == NIL || r_k + 1'b1 >= (IW+1)'(CAPACITY)) begin
                        n_rsp = mk(dll_pkg::ST_MISS, '0, r_cnt, 1'b1);
                        n_state = dll_pkg::S_DONE;
                    end else begin
                        n_k = r_k + 1'b1; n_cur = rn; n_state = dll_pkg::S_WALK;
                    end
                end else if (9'(r_k) < {1'b0, r_pos}) begin
                    n_k = r_k + 1'b1; n_cur = rn; n_state = dll_pkg::S_WALK;
                end else if (is_ins) begin
                    n_x = r_cur; n_p = rp; n_state = dll_pkg::S_LINK_A;
                end else begin
                    n_node = r_cur; n_p = rp; n_x = rn; n_rh = rh;
                    if (is_rm) n_state = dll_pkg::S_UNLINK;
                    else begin
                        n_rsp = mk(dll_pkg::ST_OK, rh, r_cnt, 1'b1);
                        n_state = dll_pkg::S_DONE;
                    end
                end
            end
            dll_pkg::S_LINK_A: begin
                we_h = 1'b1; we_n = 1'b1; we_p = 1'b1;
                waddr = r_node; wn = r_x; wp = r_p;
                if (!r_alloc_free) n_nun = r_nun + 1'b1;
                if (r_x == NIL) n_tail = r_node;
                if (r_p == NIL) n_head = r_node;
                n_cnt = r_cnt + 1'b1;
                n_state = dll_pkg::S_LINK_B;
            end
            dll_pkg::S_LINK_B: begin
                if (r_p != NIL) begin
                    we_n = 1'b1; waddr = r_p; wn = r_node;
                end
                if (r_x != NIL) begin
                    n_state = dll_pkg::S_UNLINK_B;
                    n_k = {1'b1, {IW{1'b0}}};
                end else begin
                    n_rsp = mk(dll_pkg::ST_OK, '0, r_cnt, 1'b1);
                    n_state = dll_pkg::S_DONE;
                end
            end
            dll_pkg::S_UNLINK: begin
                if (r_p != NIL) begin
                    we_n = 1'b1; waddr = r_p; wn = r_x;
                end else n_head = r_x;
                if (r_x == NIL) n_tail = r_p;
                n_cnt = r_cnt - 1'b1;
                n_k = '0;
                n_state = dll_pkg::S_UNLINK_B;
            end
            dll_pkg::S_UNLINK_B: begin
                if (r_k[IW]) begin
                    we_p = 1'b1; waddr = r_x; wp = r_node;
                    n_rsp = mk(dll_pkg::ST_OK, '0, r_cnt, 1'b1);
                    n_state = dll_pkg::S_DONE;
                end else begin
                    if (r_x != NIL) begin
                        we_p = 1'b1; waddr = r_x; wp = r_p;
                    end
                    n_k = {1'b1, {IW{1'b0}}};
                    n_state = dll_pkg::S_TRAV;
                end
            end
            dll_pkg::S_TRAV: begin
                we_n = 1'b1; waddr = r_node; wn = r_free;
                n_free = r_node;
                n_rsp = mk(dll_pkg::ST_OK, r_rh, r_cnt, 1'b1);
                n_state = dll_pkg::S_DONE;
            end
            dll_pkg::S_DONE: begin
                n_ov = 1'b1;
                n_state = dll_pkg::S_IDLE;
            end
            default: n_state = dll_pkg::S_IDLE;
        endcase
    end
endmodule

[rtl/core/dll_checker.sv]
// dll_checker: port-level checks on the list engine, bound to its top level.
// Depends on dll_pkg.
module dll_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input dll_pkg::t_rsp o_rsp
);
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.is_empty == (o_rsp.element_count == '0)))
        else $error("empty flag disagrees with count");
    a_zero_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != dll_pkg::ST_OK) |-> (o_rsp.result_handle == '0))
        else $error("handle not zero on failure");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.last) |-> !busy)
        else $error("busy during final result");
    a_busy_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request not taken");
endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_rsp(o_rsp)
);

[tb/sv/doubly_linked_list_engine_tb.sv]
// Testbench for doubly_linked_list_engine: drives list operations and checks
// every result against a built-in model of the linked list and node store.
// Depends on dll_pkg and the engine RTL.
module doubly_linked_list_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 64;
    localparam int NIL = CAP;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    dll_pkg::t_req  i_req = '0;
    logic           o_valid;
    dll_pkg::t_rsp  o_rsp;

    doubly_linked_list_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    // model of the node store
    logic [31:0] mdl_handle [CAP];
    int          mdl_next [CAP];
    int          mdl_prev [CAP];
    int          mdl_head, mdl_tail, mdl_count, mdl_free, mdl_fresh;

    dll_pkg::t_rsp rsp_pending [$];
    int            n_errors = 0;
    bit            idle_on = 1'b1;

    function automatic void mdl_reset();
        mdl_head = NIL; mdl_tail = NIL; mdl_count = 0;
        mdl_free = NIL; mdl_fresh = 0;
    endfunction

    function automatic void push_rsp(dll_pkg::t_status st, logic [31:0] h, bit lst);
        dll_pkg::t_rsp r;
        r.status        = st;
        r.result_handle = (st == dll_pkg::ST_OK) ? h : '0;
        r.element_count = mdl_count[6:0];
        r.is_empty      = (mdl_count == 0);
        r.last          = lst;
        rsp_pending.push_back(r);
    endfunction

    function automatic int node_at(int pos);
        int cur;
        cur = mdl_head;
        for (int i = 0; i < pos && cur < NIL; i++) cur = mdl_next[cur];
        return cur;
    endfunction

    function automatic int find_node(logic [31:0] h);
        int cur;
        cur = mdl_head;
        for (int s = 0; s < CAP && cur < NIL; s++) begin
            if (mdl_handle[cur] == h) return cur;
            cur = mdl_next[cur];
        end
        return NIL;
    endfunction

    function automatic logic [31:0] unlink(int n);
        int p, x;
        p = mdl_prev[n];
        x = mdl_next[n];
        if (p < NIL) mdl_next[p] = x; else mdl_head = x;
        if (x < NIL) mdl_prev[x] = p; else mdl_tail = p;
        mdl_next[n] = mdl_free;
        mdl_free = n;
        mdl_count--;
        return mdl_handle[n];
    endfunction

    function automatic dll_pkg::t_status link_before(int nxt, logic [31:0] h);
        int n, p;
        if (mdl_free < NIL) begin
            n = mdl_free;
            mdl_free = mdl_next[n];
        end else if (mdl_fresh < NIL) begin
            n = mdl_fresh;
            mdl_fresh++;
        end else begin
            return dll_pkg::ST_FULL;
        end
        mdl_handle[n] = h;
        p = (nxt < NIL) ? mdl_prev[nxt] : mdl_tail;
        mdl_prev[n] = p;
        mdl_next[n] = nxt;
        if (p < NIL) mdl_next[p] = n; else mdl_head = n;
        if (nxt < NIL) mdl_prev[nxt] = n; else mdl_tail = n;
        mdl_count++;
        return dll_pkg::ST_OK;
    endfunction

    function automatic void predict_list_op(dll_pkg::t_req q);
        dll_pkg::t_status st;
        logic [31:0]      rh;
        int               n, k;
        st = dll_pkg::ST_MISS;
        rh = '0;
        case (q.mode)
            dll_pkg::OP_INS_FRONT: st = link_before(mdl_head, q.handle);
            dll_pkg::OP_INS_BACK:  st = link_before(NIL, q.handle);
            dll_pkg::OP_INS_POS:
                st = link_before(q.position >= mdl_count ? NIL : node_at(q.position),
                                 q.handle);
            dll_pkg::OP_RM_FRONT:
                if (mdl_head < NIL) begin rh = unlink(mdl_head); st = dll_pkg::ST_OK; end
            dll_pkg::OP_RM_BACK:
                if (mdl_tail < NIL) begin rh = unlink(mdl_tail); st = dll_pkg::ST_OK; end
            dll_pkg::OP_RM_POS:
                if (q.position < mdl_count) begin
                    rh = unlink(node_at(q.position));
                    st = dll_pkg::ST_OK;
                end
            dll_pkg::OP_RM_VALUE: begin
                n = find_node(q.handle);
                if (n < NIL) begin rh = unlink(n); st = dll_pkg::ST_OK; end
            end
            dll_pkg::OP_READ_POS:
                if (q.position < mdl_count) begin
                    rh = mdl_handle[node_at(q.position)];
                    st = dll_pkg::ST_OK;
                end
            dll_pkg::OP_READ_FRNT:
                if (mdl_head < NIL) begin rh = mdl_handle[mdl_head]; st = dll_pkg::ST_OK; end
            dll_pkg::OP_READ_BACK:
                if (mdl_tail < NIL) begin rh = mdl_handle[mdl_tail]; st = dll_pkg::ST_OK; end
            dll_pkg::OP_SEARCH: begin
                n = find_node(q.handle);
                if (n < NIL) begin rh = mdl_handle[n]; st = dll_pkg::ST_OK; end
            end
            dll_pkg::OP_TRAVERSE:
                if (mdl_head < NIL) begin
                    n = mdl_head;
                    k = 0;
                    while (n < NIL && k < CAP) begin
                        push_rsp(dll_pkg::ST_OK, mdl_handle[n],
                                 mdl_next[n] >= NIL || k + 1 >= CAP);
                        n = mdl_next[n];
                        k++;
                    end
                    return;
                end
            dll_pkg::OP_CLEAR: begin
                mdl_reset();
                st = dll_pkg::ST_OK;
            end
            default: ;
        endcase
        push_rsp(st, rh, 1'b1);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        dll_pkg::t_rsp e;
        if (i_rst_n && o_valid) begin
            if (rsp_pending.size() == 0) begin
                $error("unexpected result %p", o_rsp);
                n_errors++;
            end else begin
                e = rsp_pending.pop_front();
                if (o_rsp.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_rsp.status); n_errors++;
                end
                if (o_rsp.result_handle !== e.result_handle) begin
                    $error("result_handle exp %h got %h", e.result_handle,
                           o_rsp.result_handle);
                    n_errors++;
                end
                if (o_rsp.element_count !== e.element_count) begin
                    $error("element_count exp %0d got %0d", e.element_count,
                           o_rsp.element_count);
                    n_errors++;
                end
                if (o_rsp.is_empty !== e.is_empty) begin
                    $error("is_empty exp %0d got %0d", e.is_empty, o_rsp.is_empty);
                    n_errors++;
                end
                if (o_rsp.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_rsp.last); n_errors++;
                end
            end
        end
    end

    // one request: hold start until accepted, model it at acceptance
    task automatic send_req(logic [3:0] mode, logic [31:0] h, logic [7:0] pos);
        dll_pkg::t_req q;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        q.mode = mode;
        q.handle = h;
        q.position = pos;
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        predict_list_op(q);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (rsp_pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_handle();
        int c;
        c = $urandom_range(0, 5);
        if (c == 0) return 32'hFFFF_FFFF;
        if (c == 1) return '0;
        if (c < 4) return $urandom_range(0, 15);
        return $urandom;
    endfunction

    task automatic test_empty_cases();
        for (int m = dll_pkg::OP_RM_FRONT; m <= dll_pkg::OP_CLEAR; m++)
            send_req(4'(m), 32'h5, 8'd0);
        send_req(4'd13, '0, '0);
        send_req(4'd15, 32'hFFFF_FFFF, 8'hFF);
        wait_drained();
    endtask

    task automatic test_basic_ops();
        send_req(dll_pkg::OP_INS_BACK, 32'hFFFF_FFFF, 8'd0);
        send_req(dll_pkg::OP_INS_FRONT, 32'h0, 8'd0);
        send_req(dll_pkg::OP_INS_POS, 32'hA5A5_5A5A, 8'd1);
        send_req(dll_pkg::OP_INS_POS, 32'h1234_5678, 8'hFF);
        send_req(dll_pkg::OP_READ_POS, '0, 8'd2);
        send_req(dll_pkg::OP_READ_POS, '0, 8'd4);
        send_req(dll_pkg::OP_READ_FRNT, '0, '0);
        send_req(dll_pkg::OP_READ_BACK, '0, '0);
        send_req(dll_pkg::OP_SEARCH, 32'hA5A5_5A5A, '0);
        send_req(dll_pkg::OP_SEARCH, 32'h7, '0);
        send_req(dll_pkg::OP_TRAVERSE, '0, '0);
        send_req(dll_pkg::OP_RM_VALUE, 32'h0, '0);
        send_req(dll_pkg::OP_RM_VALUE, 32'h9, '0);
        send_req(dll_pkg::OP_RM_POS, '0, 8'd1);
        send_req(dll_pkg::OP_RM_POS, '0, 8'd9);
        send_req(dll_pkg::OP_RM_FRONT, '0, '0);
        send_req(dll_pkg::OP_RM_BACK, '0, '0);
        send_req(dll_pkg::OP_CLEAR, '0, '0);
        wait_drained();
    endtask

    task automatic test_full_store();
        for (int i = 0; i < CAP; i++) send_req(dll_pkg::OP_INS_BACK, $urandom, '0);
        send_req(dll_pkg::OP_INS_FRONT, 32'h1, '0);
        send_req(dll_pkg::OP_INS_POS, 32'h2, 8'd3);
        send_req(dll_pkg::OP_TRAVERSE, '0, '0);
        send_req(dll_pkg::OP_READ_POS, '0, 8'd63);
        send_req(dll_pkg::OP_RM_POS, '0, 8'd63);
        send_req(dll_pkg::OP_RM_POS, '0, 8'd10);
        send_req(dll_pkg::OP_INS_POS, 32'h3, 8'd5);
        send_req(dll_pkg::OP_CLEAR, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_ops(int n_ops);
        logic [3:0] m;
        logic [7:0] p;
        int         c;
        for (int i = 0; i < n_ops; i++) begin
            c = $urandom_range(0, 99);
            if (c < 40)
                m = 4'($urandom_range(dll_pkg::OP_INS_FRONT, dll_pkg::OP_INS_POS));
            else if (c < 96)
                m = 4'($urandom_range(dll_pkg::OP_RM_FRONT, dll_pkg::OP_TRAVERSE));
            else if (c < 98)
                m = dll_pkg::OP_CLEAR;
            else
                m = 4'($urandom_range(13, 15));
            p = $urandom_range(0, 1) ? 8'($urandom_range(0, 70))
                                     : 8'($urandom_range(0, 255));
            send_req(m, pick_handle(), p);
            if (i == n_ops / 2) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        mdl_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_cases();
        test_basic_ops();
        test_full_store();
        test_random_ops(120);
        idle_on = 1'b0;
        test_random_ops(60);
        if (n_errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
